@@ hw/rtl/mpfb_pkg.sv @@
// Package for the page-organized monochrome framebuffer engine.
// Holds field widths, request and register codes, and the sequencer states.
// No dependencies; every other file imports it.
package mpfb_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH    = 128;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_GLYPH_WIDTH  = 8;
  localparam int DEF_GLYPH_HEIGHT = 8;

  // Word field widths
  localparam int REQ_TYPE_W = 3;
  localparam int POS_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 10;
  localparam int ROFF_W     = 4;

  // Configuration port
  localparam int AW_W       = 8;
  localparam int AH_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Internal arithmetic widths, sized for the full parameter ranges
  // (width up to 256, height up to 128, cursor plus glyph offsets)
  localparam int COORD_W     = 9;
  localparam int HEFF_W      = 8;
  localparam int PAGE_W      = 6;
  localparam int LIN_W       = 16;
  localparam int PAGE_SHIFT  = 3;
  localparam int GLYPH_BIT_W = 3;
  localparam logic [GLYPH_BIT_W-1:0] GLYPH_MSB = 3'd7;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_PIXEL  = 3'd0,
    REQ_FILL   = 3'd1,
    REQ_READ   = 3'd2,
    REQ_GLYPH  = 3'd3,
    REQ_CURSOR = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 1'b0,
    CFG_ACTIVE_HEIGHT = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIZE,
    ST_LIN,
    ST_RMW,
    ST_FILL,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_DONE
  } state_e;

endpackage

@@ hw/rtl/mpfb_if.sv @@
// Request and response channel interfaces for the framebuffer engine.
// Depends on mpfb_pkg for the field widths.
interface mpfb_req_if import mpfb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic                  pixel_on;
  logic [BYTE_W-1:0]     data_byte;
  logic [INDEX_W-1:0]    byte_index;
  logic [ROFF_W-1:0]     row_offset;
  logic                  last_row;

  modport source (output valid, req_type, pos_x, pos_y, pixel_on, data_byte, byte_index,
                  row_offset, last_row, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pixel_on, data_byte, byte_index,
                row_offset, last_row, output ready);
endinterface

interface mpfb_rsp_if import mpfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              index_error;
  logic [POS_W-1:0]  cursor_col;
  logic [POS_W-1:0]  cursor_row;

  modport source (output valid, read_data, index_error, cursor_col, cursor_row,
                  input ready);
  modport sink (input valid, read_data, index_error, cursor_col, cursor_row,
                output ready);
endinterface

@@ hw/rtl/mpfb_muladd.sv @@
// Shared multiply-add unit: a * b + c, used for page*width+column and for
// the active byte count. Depends on mpfb_pkg.
module mpfb_muladd import mpfb_pkg::*; (
  input  logic [PAGE_W-1:0]  a_i,
  input  logic [COORD_W-1:0] b_i,
  input  logic [COORD_W-1:0] c_i,
  output logic [LIN_W-1:0]   sum_o
);

  logic [PAGE_W+COORD_W-1:0] prod;

  assign prod  = a_i * b_i;
  assign sum_o = LIN_W'(prod) + LIN_W'(c_i);

endmodule

@@ hw/rtl/mpfb_store.sv @@
// Frame store: one write port, one read port with registered read data.
// Depends on mpfb_pkg for BYTE_W and the default depth.
module mpfb_store import mpfb_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_WIDTH * (DEF_MAX_HEIGHT / 8),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mono_page_framebuffer_engine_unit.sv @@
// Monochrome page framebuffer engine: pixel, fill, byte read, glyph row, cursor set.
// Each word passes a size step; pixels then form the address and read-modify-write, reads
// check the index and fetch the byte, fills write each active byte, glyph rows visit each
// bit with a read-modify-write for set bits only. One word is in flight at a time; the rate
// is set by the read-modify-write through the shared multiply-add unit and the store. After
// reset the store is swept to zero, one byte per cycle, 1024 bytes by default; no word is taken.
module mono_page_framebuffer_engine_unit import mpfb_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpfb_req_if.sink              req_i,
  mpfb_rsp_if.source            rsp_o
);

  localparam int STORE_DEPTH = MAX_WIDTH * (MAX_HEIGHT / 8);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [LIN_W-1:0]       DEPTH_L   = LIN_W'(STORE_DEPTH);
  localparam logic [LIN_W-1:0]       LAST_ADDR = LIN_W'(STORE_DEPTH - 1);
  localparam logic [COORD_W-1:0]     MAX_W_L   = COORD_W'(MAX_WIDTH);
  localparam logic [HEFF_W-1:0]      MAX_H_L   = HEFF_W'(MAX_HEIGHT);
  localparam logic [GLYPH_BIT_W-1:0] GW_LAST   = GLYPH_BIT_W'(GLYPH_WIDTH - 1);
  localparam logic [COORD_W-1:0]     GW_STEP   = COORD_W'(GLYPH_WIDTH);
  localparam logic [COORD_W-1:0]     GH_STEP   = COORD_W'(GLYPH_HEIGHT);

  // Configuration registers
  logic [AW_W-1:0] aw_q;
  logic [AH_W-1:0] ah_q;

  // Sequencer and working registers
  state_e                  state_q, state_d;
  logic [LIN_W-1:0]        cnt_q, cnt_d;
  logic [LIN_W-1:0]        lin_q, lin_d;
  logic                    lin_ok_q, lin_ok_d;
  logic [GLYPH_BIT_W-1:0]  bit_q, bit_d;
  logic [LIN_W-1:0]        nbytes_q, nbytes_d;
  logic [BYTE_W-1:0]       rd_q, rd_d;
  logic                    err_q, err_d;
  logic [POS_W-1:0]        col_q, col_d;
  logic [POS_W-1:0]        row_q, row_d;

  // Captured request word
  req_e                    req_q;
  logic [POS_W-1:0]        px_q, py_q;
  logic                    on_q;
  logic [BYTE_W-1:0]       data_q;
  logic [INDEX_W-1:0]      idx_q;
  logic [ROFF_W-1:0]       roff_q;
  logic                    last_q;

  // Response register
  logic                    rsp_valid_q;
  logic [BYTE_W-1:0]       rsp_data_q;
  logic                    rsp_err_q;
  logic [POS_W-1:0]        rsp_col_q, rsp_row_q;

  logic                    req_fire, rsp_load, glyph_end;
  logic [COORD_W-1:0]      w_eff;
  logic [HEFF_W-1:0]       h_eff;
  logic [COORD_W-1:0]      x_sel, y_sel;
  logic [COORD_W-1:0]      adv_col, adv_row;
  logic [LIN_W-1:0]        idx_ext, cnt_next;
  logic [BYTE_W-1:0]       pix_mask;
  logic                    set_bit, in_range, glyph_bit;

  // Shared unit and store ports
  logic [PAGE_W-1:0]       mul_a;
  logic [COORD_W-1:0]      mul_b, mul_c;
  logic [LIN_W-1:0]        lin_sum;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]       mem_wdata, mem_rdata;

  mpfb_muladd u_muladd (
    .a_i   (mul_a),
    .b_i   (mul_b),
    .c_i   (mul_c),
    .sum_o (lin_sum)
  );

  mpfb_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Clamp oversized register values to the store geometry
  assign w_eff = ({1'b0, aw_q} > MAX_W_L) ? MAX_W_L : {1'b0, aw_q};
  assign h_eff = ({1'b0, ah_q} > MAX_H_L) ? MAX_H_L : {1'b0, ah_q};

  // Pixel coordinates: the request's own, or cursor plus glyph offsets
  assign x_sel = (req_q == REQ_GLYPH) ? ({1'b0, col_q} + COORD_W'(bit_q)) : {1'b0, px_q};
  assign y_sel = (req_q == REQ_GLYPH) ? ({1'b0, row_q} + COORD_W'(roff_q)) : {1'b0, py_q};

  // A row in a partial last page lands at or past the active byte count and drops out there
  assign in_range = (x_sel < w_eff) && (y_sel < COORD_W'(h_eff))
                  && (lin_sum < nbytes_q) && (lin_sum < DEPTH_L);

  assign pix_mask  = BYTE_W'(1) << y_sel[PAGE_SHIFT-1:0];
  assign set_bit   = (req_q == REQ_GLYPH) ? 1'b1 : on_q;
  assign glyph_bit = data_q[GLYPH_BIT_W'(GLYPH_MSB - bit_q)];
  assign idx_ext   = LIN_W'(idx_q);
  assign cnt_next  = cnt_q + LIN_W'(1);

  // Cursor advance: line wrap on the column, then screen wrap on the row
  always_comb begin
    adv_col = {1'b0, col_q} + GW_STEP;
    adv_row = {1'b0, row_q};
    if (adv_col >= w_eff) begin
      adv_col = '0;
      adv_row = {1'b0, row_q} + GH_STEP;
    end
    if (adv_row >= COORD_W'(h_eff)) begin
      adv_row = '0;
    end
  end

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lin_d     = lin_q;
    lin_ok_d  = lin_ok_q;
    bit_d     = bit_q;
    nbytes_d  = nbytes_q;
    rd_d      = rd_q;
    err_d     = err_q;
    col_d     = col_q;
    row_d     = row_q;
    rsp_load  = 1'b0;
    glyph_end = 1'b0;
    mul_a     = y_sel[COORD_W-1:PAGE_SHIFT];
    mul_b     = w_eff;
    mul_c     = x_sel;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[ADDR_W-1:0];
    mem_wdata = '0;
    mem_raddr = lin_sum[ADDR_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_next;
        end
      end

      ST_IDLE: begin
        if (req_fire) begin
          rd_d    = '0;
          err_d   = 1'b0;
          bit_d   = '0;
          state_d = ST_SIZE;
        end
      end

      ST_SIZE: begin
        // Active byte count = width * whole pages
        mul_a    = PAGE_W'(h_eff >> PAGE_SHIFT);
        mul_c    = '0;
        nbytes_d = lin_sum;
        unique case (req_q)
          REQ_PIXEL, REQ_GLYPH: state_d = ST_LIN;
          REQ_FILL: begin
            cnt_d   = '0;
            state_d = (lin_sum == '0) ? ST_DONE : ST_FILL;
          end
          REQ_READ: state_d = ST_READ_ADDR;
          REQ_CURSOR: begin
            col_d   = px_q;
            row_d   = py_q;
            state_d = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end

      ST_LIN: begin
        // Compute the byte address and start its read in the same cycle
        lin_d    = lin_sum;
        lin_ok_d = in_range;
        if ((req_q == REQ_GLYPH) && !glyph_bit) begin
          if (bit_q == GW_LAST) begin
            glyph_end = 1'b1;
            state_d   = ST_DONE;
          end else begin
            bit_d = bit_q + GLYPH_BIT_W'(1);
          end
        end else begin
          state_d = ST_RMW;
        end
      end

      ST_RMW: begin
        mem_we    = lin_ok_q;
        mem_waddr = lin_q[ADDR_W-1:0];
        mem_wdata = set_bit ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
        if (req_q != REQ_GLYPH) begin
          state_d = ST_DONE;
        end else if (bit_q == GW_LAST) begin
          glyph_end = 1'b1;
          state_d   = ST_DONE;
        end else begin
          bit_d   = bit_q + GLYPH_BIT_W'(1);
          state_d = ST_LIN;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = data_q;
        if ((cnt_next >= nbytes_q) || (cnt_next >= DEPTH_L)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_next;
        end
      end

      ST_READ_ADDR: begin
        mem_raddr = idx_ext[ADDR_W-1:0];
        if ((idx_ext >= nbytes_q) || (idx_ext >= DEPTH_L)) begin
          err_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ_DATA;
        end
      end

      ST_READ_DATA: begin
        rd_d    = mem_rdata;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the response register is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (glyph_end && last_q) begin
      col_d = adv_col[POS_W-1:0];
      row_d = adv_row[POS_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      bit_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      aw_q        <= AW_W'(128);
      ah_q        <= AH_W'(64);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_ACTIVE_WIDTH:  aw_q <= cfg_data_i[AW_W-1:0];
          CFG_ACTIVE_HEIGHT: ah_q <= cfg_data_i[AH_W-1:0];
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lin_q    <= lin_d;
    lin_ok_q <= lin_ok_d;
    nbytes_q <= nbytes_d;
    rd_q     <= rd_d;
    err_q    <= err_d;
    if (req_fire) begin
      req_q  <= req_e'(req_i.req_type);
      px_q   <= req_i.pos_x;
      py_q   <= req_i.pos_y;
      on_q   <= req_i.pixel_on;
      data_q <= req_i.data_byte;
      idx_q  <= req_i.byte_index;
      roff_q <= req_i.row_offset;
      last_q <= req_i.last_row;
    end
    if (rsp_load) begin
      rsp_data_q <= rd_q;
      rsp_err_q  <= err_q;
      rsp_col_q  <= col_q;
      rsp_row_q  <= row_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_data_q;
  assign rsp_o.index_error = rsp_err_q;
  assign rsp_o.cursor_col  = rsp_col_q;
  assign rsp_o.cursor_row  = rsp_row_q;

endmodule
